[rtl/rc_packet_differential_drive_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the RC packet differential drive block
// Concurrent checks on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef RC_PACKET_DIFFERENTIAL_DRIVE_TOP_MACROS_SVH
`define RC_PACKET_DIFFERENTIAL_DRIVE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent and consequent in the same cycle
`define RCDD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rcdd: same-cycle check failed");

// consequent in the cycle after the antecedent
`define RCDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rcdd: next-cycle check failed");

`else

`define RCDD_ASSERT_SAME(lbl, ante, cons)
`define RCDD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/rcdd_pkg.sv]
// ----------------------------------------------------------------------------
// rcdd_pkg
// Types, codes and constants shared by the RC packet differential drive block.
// ----------------------------------------------------------------------------
package rcdd_pkg;

    // packet headers
    localparam logic [7:0] HDR_CMD_A = 8'hBB;
    localparam logic [7:0] HDR_CMD_B = 8'hBA;
    localparam logic [7:0] HDR_JOY   = 8'hAA;

    // commands (bit 0 of the command byte is ignored)
    localparam logic [7:0] CMD_MASK        = 8'hFE;
    localparam logic [7:0] CMD_FIRST_SERVO = 8'd30;
    localparam logic [7:0] CMD_SECOND_SERVO = 8'd40;
    localparam logic [7:0] CMD_HEADLIGHT   = 8'd20;
    localparam logic [7:0] CMD_LED         = 8'd10;

    // configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [1:0] CFG_STEER_FORCE  = 2'd1;
    localparam logic [1:0] CFG_THROTTLE_MAX = 2'd2;

    localparam logic [15:0] DEBOUNCE_RST     = 16'd200;
    localparam logic [8:0]  STEER_FORCE_RST  = 9'd150;
    localparam logic [10:0] THROTTLE_MAX_RST = 11'd1300;

    typedef enum logic [1:0] {
        KIND_IGNORED  = 2'd0,
        KIND_COMMAND  = 2'd1,
        KIND_JOYSTICK = 2'd2
    } packet_kind_t;

    // servo angles
    localparam logic [7:0] ANGLE_MIN  = 8'd0;
    localparam logic [7:0] ANGLE_STEP = 8'd30;
    localparam logic [7:0] ANGLE_MID  = 8'd90;
    localparam logic [7:0] ANGLE_MAX  = 8'd180;

    // motor pulse limits and stick map
    localparam logic [10:0] PULSE_MIN = 11'd1000;
    localparam logic [10:0] PULSE_MAX = 11'd2000;
    localparam logic [7:0]  Y_DEAD    = 8'd18;
    localparam logic [7:0]  X_DEAD    = 8'd27;
    localparam logic [7:0]  STICK_TOP = 8'd62;

    // floor(p/44) = (p*THR_RECIP) >> THR_SHIFT for p <= 44000
    localparam logic [15:0] THR_RECIP   = 16'd47663;
    localparam int          THR_SHIFT   = 21;
    // floor(p/35) = (p*STEER_RECIP) >> STEER_SHIFT for p <= 17885
    localparam logic [14:0] STEER_RECIP = 15'd29960;
    localparam int          STEER_SHIFT = 20;

    typedef struct packed {
        logic [15:0] throttle;   // (y - 18) * (tmax - 1000)
        logic [14:0] steer;      // (x - 27) * steer force
    } drive_prod_t;

    typedef struct packed {
        logic [10:0] right;
        logic [10:0] left;
    } drive_out_t;

    typedef struct packed {
        logic [11:0] first_pulse;
        logic [11:0] second_pulse;
        logic        headlight;
        logic        led;
        logic        unknown;
    } cmd_out_t;

    function automatic logic [10:0] sat_tmax(input logic [10:0] t);
        logic [10:0] r;
        r = t;
        if (t < PULSE_MIN) r = PULSE_MIN;
        if (t > PULSE_MAX) r = PULSE_MAX;
        return r;
    endfunction

    // 500 + 2000*angle/180 for the angles the servos can reach
    function automatic logic [11:0] servo_pulse(input logic [7:0] angle);
        logic [11:0] r;
        case (angle)
            8'd0:    r = 12'd500;
            8'd30:   r = 12'd833;
            8'd60:   r = 12'd1166;
            8'd90:   r = 12'd1500;
            8'd120:  r = 12'd1833;
            8'd150:  r = 12'd2166;
            8'd180:  r = 12'd2500;
            default: r = 12'd500;
        endcase
        return r;
    endfunction

endpackage

[rtl/rcdd_drive_pre.sv]
// ----------------------------------------------------------------------------
// rcdd_drive_pre
// Stick deadzone/clip and the two scaling products, ahead of the input register.
// ----------------------------------------------------------------------------
module rcdd_drive_pre
    import rcdd_pkg::*;
(
    input  logic [7:0]  stick_x,
    input  logic [7:0]  stick_y,
    input  logic [8:0]  steer_force,
    input  logic [10:0] throttle_max,
    output drive_prod_t prod
);

    logic [10:0] tmax;
    logic [9:0]  span;
    logic [7:0]  y_clip;
    logic [7:0]  x_clip;
    logic [5:0]  dy;
    logic [5:0]  dx;

    always_comb begin
        tmax   = sat_tmax(throttle_max);
        span   = 10'(tmax - PULSE_MIN);
        y_clip = (stick_y > STICK_TOP) ? STICK_TOP : stick_y;
        x_clip = (stick_x > STICK_TOP) ? STICK_TOP : stick_x;
        // inside the deadzone the product is zero, which maps to 1000 / no steering
        dy     = (stick_y > Y_DEAD) ? 6'(y_clip - Y_DEAD) : 6'd0;
        dx     = (stick_x > X_DEAD) ? 6'(x_clip - X_DEAD) : 6'd0;
        prod.throttle = 16'(dy) * 16'(span);
        prod.steer    = 15'(dx) * 15'(steer_force);
    end

endmodule

[rtl/rcdd_drive_mix.sv]
// ----------------------------------------------------------------------------
// rcdd_drive_mix
// Divides the scaled products, mixes throttle and steering, holds motor pulses.
// ----------------------------------------------------------------------------
module rcdd_drive_mix
    import rcdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic        joystick,
    input  drive_prod_t prod,
    input  logic [10:0] throttle_max,
    output drive_out_t  drive
);

    logic [10:0] right_hold_reg;
    logic [10:0] left_hold_reg;

    logic [10:0] tmax;
    logic [31:0] thr_mul;
    logic [29:0] steer_mul;
    logic [10:0] throttle;
    logic [8:0]  steer;
    logic [11:0] right_sum;
    logic [10:0] right_new;
    logic [10:0] left_new;

    always_comb begin
        tmax      = sat_tmax(throttle_max);
        thr_mul   = 32'(prod.throttle) * 32'(THR_RECIP);
        steer_mul = 30'(prod.steer) * 30'(STEER_RECIP);
        throttle  = PULSE_MIN + thr_mul[THR_SHIFT +: 11];
        steer     = (throttle == PULSE_MIN) ? 9'd0 : steer_mul[STEER_SHIFT +: 9];
        right_sum = 12'(throttle) + 12'(steer);
        right_new = (right_sum > 12'(tmax)) ? tmax : right_sum[10:0];
        // throttle never exceeds tmax, so only the low clamp matters on the left
        left_new  = (12'(throttle) >= 12'(steer) + 12'(PULSE_MIN)) ?
                    11'(throttle - 11'(steer)) : PULSE_MIN;
        drive.right = joystick ? right_new : right_hold_reg;
        drive.left  = joystick ? left_new  : left_hold_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_hold_reg <= PULSE_MIN;
            left_hold_reg  <= PULSE_MIN;
        end else if (fire && joystick) begin
            right_hold_reg <= right_new;
            left_hold_reg  <= left_new;
        end
    end

endmodule

[rtl/rcdd_cmd.sv]
// ----------------------------------------------------------------------------
// rcdd_cmd
// Command decoder: servo step cycles and debounced light toggles.
// ----------------------------------------------------------------------------
module rcdd_cmd
    import rcdd_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic                 is_cmd,
    input  logic [7:0]           cmd_byte,
    input  logic [TIME_BITS-1:0] now_ms,
    input  logic [15:0]          debounce_ms,
    output cmd_out_t             status
);

    logic [7:0]           first_angle_reg, first_angle_next;
    logic [7:0]           second_angle_reg, second_angle_next;
    logic [TIME_BITS-1:0] headlight_stamp_reg, headlight_stamp_next;
    logic [TIME_BITS-1:0] led_stamp_reg, led_stamp_next;
    logic                 headlight_reg, headlight_next;
    logic                 led_reg, led_next;

    logic [7:0]           cmd;
    logic [TIME_BITS-1:0] headlight_age;
    logic [TIME_BITS-1:0] led_age;
    logic                 headlight_ok;
    logic                 led_ok;
    logic                 unknown;

    always_comb begin
        cmd           = cmd_byte & CMD_MASK;
        // elapsed time wraps with the counter
        headlight_age = now_ms - headlight_stamp_reg;
        led_age       = now_ms - led_stamp_reg;
        headlight_ok  = headlight_age >= TIME_BITS'(debounce_ms);
        led_ok        = led_age >= TIME_BITS'(debounce_ms);

        first_angle_next     = first_angle_reg;
        second_angle_next    = second_angle_reg;
        headlight_stamp_next = headlight_stamp_reg;
        led_stamp_next       = led_stamp_reg;
        headlight_next       = headlight_reg;
        led_next             = led_reg;
        unknown              = 1'b0;

        if (is_cmd) begin
            case (cmd)
                CMD_FIRST_SERVO: begin
                    first_angle_next = (first_angle_reg > ANGLE_MID) ?
                                       first_angle_reg - ANGLE_STEP : ANGLE_MAX;
                end
                CMD_SECOND_SERVO: begin
                    second_angle_next = (second_angle_reg < ANGLE_MID) ?
                                        second_angle_reg + ANGLE_STEP : ANGLE_MIN;
                end
                CMD_HEADLIGHT: begin
                    if (headlight_ok) begin
                        headlight_next       = !headlight_reg;
                        headlight_stamp_next = now_ms;
                    end
                end
                CMD_LED: begin
                    if (led_ok) begin
                        led_next       = !led_reg;
                        led_stamp_next = now_ms;
                    end
                end
                default: begin
                    unknown = 1'b1;
                end
            endcase
        end

        status.first_pulse  = servo_pulse(first_angle_next);
        status.second_pulse = servo_pulse(second_angle_next);
        status.headlight    = headlight_next;
        status.led          = led_next;
        status.unknown      = unknown;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_angle_reg     <= ANGLE_MAX;
            second_angle_reg    <= ANGLE_MIN;
            headlight_stamp_reg <= '0;
            led_stamp_reg       <= '0;
            headlight_reg       <= 1'b0;
            led_reg             <= 1'b0;
        end else if (fire) begin
            first_angle_reg     <= first_angle_next;
            second_angle_reg    <= second_angle_next;
            headlight_stamp_reg <= headlight_stamp_next;
            led_stamp_reg       <= led_stamp_next;
            headlight_reg       <= headlight_next;
            led_reg             <= led_next;
        end
    end

endmodule

[rtl/rc_packet_differential_drive_top.sv]
// ----------------------------------------------------------------------------
// rc_packet_differential_drive_top
// Radio packet decoder for a differential-drive boat: servos, lights, motors.
//
//   port group   dir   content
//   s_*          in    packet: tuser header, tdata X/cmd, Y, now_ms
//   m_*          out   actuator levels, tuser packet kind and unknown flag
//   cfg_*        in    register writes: debounce, steering force, throttle max
//
// One packet per cycle sustained while m_tready is high. From the input
// transaction to m_tvalid: input register, then decode/mix into the result
// register. The two products are formed before the input register; the
// constant divisions and the mix sit between the input and result registers.
// Reset is synchronous (aresetn low); data registers are not reset, all other
// state is. A stall on m_tready holds the result and backs up s_tready.
// ----------------------------------------------------------------------------
`include "rc_packet_differential_drive_top_macros.svh"

module rc_packet_differential_drive_top
    import rcdd_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // payload_first[7:0], payload_second[15:8], now_ms[TIME_BITS+15:16], zero fill
    input  logic [((16+TIME_BITS+7)/8)*8-1:0] s_tdata,
    // header[7:0]
    input  logic [7:0]           s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // right_esc_us[10:0], left_esc_us[21:11], first_servo_us[33:22],
    // second_servo_us[45:34], headlight_on[46], led_on[47]
    output logic [47:0]          m_tdata,
    // packet_kind[1:0], unknown_command[2]
    output logic [2:0]           m_tuser,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    // configuration
    logic [15:0] debounce_reg;
    logic [8:0]  steer_force_reg;
    logic [10:0] throttle_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg     <= DEBOUNCE_RST;
            steer_force_reg  <= STEER_FORCE_RST;
            throttle_max_reg <= THROTTLE_MAX_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEBOUNCE:     debounce_reg     <= cfg_data;
                CFG_STEER_FORCE:  steer_force_reg  <= cfg_data[8:0];
                CFG_THROTTLE_MAX: throttle_max_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // input register
    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           header_reg;
    logic [7:0]           first_reg;
    logic [TIME_BITS-1:0] now_reg;
    drive_prod_t          prod_reg;
    drive_prod_t          prod_in;

    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic fire;
    logic s_fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    rcdd_drive_pre u_drive_pre (
        .stick_x      (s_tdata[7:0]),
        .stick_y      (s_tdata[15:8]),
        .steer_force  (steer_force_reg),
        .throttle_max (throttle_max_reg),
        .prod         (prod_in)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            header_reg <= s_tuser;
            first_reg  <= s_tdata[7:0];
            now_reg    <= s_tdata[16 +: TIME_BITS];
            prod_reg   <= prod_in;
        end
    end

    // decode
    logic         is_cmd;
    logic         is_joy;
    packet_kind_t kind;

    always_comb begin
        is_cmd = (header_reg == HDR_CMD_A) || (header_reg == HDR_CMD_B);
        is_joy = (header_reg == HDR_JOY);
        if (is_cmd) begin
            kind = KIND_COMMAND;
        end else if (is_joy) begin
            kind = KIND_JOYSTICK;
        end else begin
            kind = KIND_IGNORED;
        end
    end

    cmd_out_t   cmd_status;
    drive_out_t drive;

    rcdd_cmd #(
        .TIME_BITS (TIME_BITS)
    ) u_cmd (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .is_cmd      (is_cmd),
        .cmd_byte    (first_reg),
        .now_ms      (now_reg),
        .debounce_ms (debounce_reg),
        .status      (cmd_status)
    );

    rcdd_drive_mix u_drive_mix (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .joystick     (is_joy),
        .prod         (prod_reg),
        .throttle_max (throttle_max_reg),
        .drive        (drive)
    );

    // result register
    logic [47:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= {cmd_status.led, cmd_status.headlight,
                            cmd_status.second_pulse, cmd_status.first_pulse,
                            drive.left, drive.right};
            m_tuser_reg <= {cmd_status.unknown, kind};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a held item is never dropped while the result side is blocked
    `RCDD_ASSERT_NEXT(a_in_held, in_valid_reg && !out_free, in_valid_reg)
    // every processed item shows up as a result in the next cycle
    `RCDD_ASSERT_NEXT(a_fire_result, fire, out_valid_reg)
    // a full input register with a blocked result side takes nothing new
    `RCDD_ASSERT_SAME(a_no_overrun, in_valid_reg && !out_free, !s_tready)
    // the unknown flag only ever comes with a command packet
    `RCDD_ASSERT_NEXT(a_unknown_cmd, fire && !is_cmd, !m_tuser_reg[2])

endmodule

[tb/sv/tb_rc_packet_differential_drive_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_packet_differential_drive_top
// Self-checking bench for the radio packet decoder. A short table of directed
// packets (reset levels, stick extremes, servo cycles, light debounce with
// time wrap) is followed by random traffic of every packet kind under several
// register settings. A local model of servo, light and motor state predicts
// every result transaction; random gaps and stalls hit both stream sides.
// ----------------------------------------------------------------------------
module tb_rc_packet_differential_drive_top
    import rcdd_pkg::*;
();

    localparam int S_W = ((16 + 32 + 7) / 8) * 8;

    typedef struct {
        logic [10:0]  right_us;
        logic [10:0]  left_us;
        logic [11:0]  first_us;
        logic [11:0]  second_us;
        logic         headlight;
        logic         led;
        packet_kind_t kind;
        logic         unknown;
    } levels_t;

    typedef struct {
        logic [7:0]  hdr;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [31:0] now;
        bit          typed;
        levels_t     want;
    } packet_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic [7:0]     s_tuser = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [47:0]    m_tdata;
    logic [2:0]     m_tuser;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_index = '0;
    logic [15:0]    cfg_data = '0;

    rc_packet_differential_drive_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // boat state as the block should hold it
    logic [15:0] cfg_debounce = DEBOUNCE_RST;
    logic [8:0]  cfg_steer    = STEER_FORCE_RST;
    logic [10:0] cfg_tmax     = THROTTLE_MAX_RST;
    int          first_angle  = 180;
    int          second_angle = 0;
    logic [31:0] headlight_stamp = '0;
    logic [31:0] led_stamp       = '0;
    logic        headlight_lvl   = 1'b0;
    logic        led_lvl         = 1'b0;
    int          right_hold = 1000;
    int          left_hold  = 1000;

    levels_t     pending_levels[$];
    packet_row_t directed_rows[$];
    levels_t     no_check;

    bit tx_gappy, rx_gappy, hold_off_req;
    int mismatches, results_seen, settings_used;
    int n_cmd, n_joy, n_ignored;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic levels_t levels(int rt, int lt, int fs, int ss, int hl, int ld,
                                       packet_kind_t k, int unk);
        levels_t r;
        r.right_us  = 11'(rt);
        r.left_us   = 11'(lt);
        r.first_us  = 12'(fs);
        r.second_us = 12'(ss);
        r.headlight = 1'(hl);
        r.led       = 1'(ld);
        r.kind      = k;
        r.unknown   = 1'(unk);
        return r;
    endfunction

    // advances the boat state by one packet and returns the output levels
    function automatic levels_t predict_boat(logic [7:0] hdr, logic [7:0] x, logic [7:0] y,
                                             logic [31:0] now);
        levels_t     r;
        logic [7:0]  cmd;
        logic [31:0] elapsed;
        int          tmax, thr, steer, xc, yc, rt, lt;
        r.kind    = KIND_IGNORED;
        r.unknown = 1'b0;
        if (hdr == HDR_CMD_A || hdr == HDR_CMD_B) begin
            r.kind = KIND_COMMAND;
            cmd = x & CMD_MASK;
            if (cmd == CMD_FIRST_SERVO) begin
                first_angle = (first_angle > 90) ? first_angle - 30 : 180;
            end else if (cmd == CMD_SECOND_SERVO) begin
                second_angle = (second_angle < 90) ? second_angle + 30 : 0;
            end else if (cmd == CMD_HEADLIGHT) begin
                elapsed = now - headlight_stamp;
                if (elapsed >= cfg_debounce) begin
                    headlight_lvl   = ~headlight_lvl;
                    headlight_stamp = now;
                end
            end else if (cmd == CMD_LED) begin
                elapsed = now - led_stamp;
                if (elapsed >= cfg_debounce) begin
                    led_lvl   = ~led_lvl;
                    led_stamp = now;
                end
            end else begin
                r.unknown = 1'b1;
            end
        end else if (hdr == HDR_JOY) begin
            r.kind = KIND_JOYSTICK;
            tmax = int'(cfg_tmax);
            if (tmax < 1000) tmax = 1000;
            if (tmax > 2000) tmax = 2000;
            thr = 1000;
            steer = 0;
            if (y > 18) begin
                yc = (y > 62) ? 62 : int'(y);
                thr = (yc - 18) * (tmax - 1000) / 44 + 1000;
            end
            // stick x at or below 27 never steers
            if (x > 27) begin
                xc = (x > 62) ? 62 : int'(x);
                steer = (xc - 27) * int'(cfg_steer) / 35;
            end
            if (thr == 1000) steer = 0;
            rt = thr + steer;
            if (rt > tmax) rt = tmax;
            lt = (thr > steer) ? thr - steer : 0;
            if (lt < 1000) lt = 1000;
            if (lt > tmax) lt = tmax;
            right_hold = rt;
            left_hold  = lt;
        end
        r.right_us  = 11'(right_hold);
        r.left_us   = 11'(left_hold);
        r.first_us  = 12'(500 + 2000 * first_angle / 180);
        r.second_us = 12'(500 + 2000 * second_angle / 180);
        r.headlight = headlight_lvl;
        r.led       = led_lvl;
        return r;
    endfunction

    task automatic add_row(input int typed, input logic [7:0] hdr, input logic [7:0] x,
                           input logic [7:0] y, input logic [31:0] now, input levels_t want);
        packet_row_t row;
        row.hdr   = hdr;
        row.x     = x;
        row.y     = y;
        row.now   = now;
        row.typed = (typed != 0);
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] x, input logic [7:0] y,
                               input logic [31:0] now, input bit typed, input levels_t want);
        int      gap;
        levels_t pred;
        gap = tx_gappy ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= hdr;
        s_tdata  <= {now, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = predict_boat(hdr, x, y, now);
        pending_levels.push_back(typed ? want : pred);
        case (pred.kind)
            KIND_COMMAND:  n_cmd++;
            KIND_JOYSTICK: n_joy++;
            default:       n_ignored++;
        endcase
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_levels.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_DEBOUNCE:     cfg_debounce = val;
            CFG_STEER_FORCE:  cfg_steer    = val[8:0];
            CFG_THROTTLE_MAX: cfg_tmax     = val[10:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (64) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall = stall - 1;
            end else begin
                m_tready <= 1'b1;
                if (rx_gappy) stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        levels_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_levels.size() == 0) begin
                $error("result transaction with no packet pending");
                mismatches++;
            end else begin
                want = pending_levels.pop_front();
                check_field("right_esc_us", int'(want.right_us), int'(m_tdata[10:0]));
                check_field("left_esc_us", int'(want.left_us), int'(m_tdata[21:11]));
                check_field("first_servo_us", int'(want.first_us), int'(m_tdata[33:22]));
                check_field("second_servo_us", int'(want.second_us), int'(m_tdata[45:34]));
                check_field("headlight_on", int'(want.headlight), int'(m_tdata[46]));
                check_field("led_on", int'(want.led), int'(m_tdata[47]));
                check_field("packet_kind", int'(want.kind), int'(m_tuser[1:0]));
                check_field("unknown_command", int'(want.unknown), int'(m_tuser[2]));
            end
        end
    end

    initial begin : stimulus
        logic [7:0]  hdr, x, y;
        logic [31:0] clock_ms;
        logic [15:0] db, sf, tm;
        int          sent, pick;
        no_check = levels(0, 0, 0, 0, 0, 0, KIND_IGNORED, 0);

        // reset levels, refused early toggles, stick extremes, unknown command
        add_row(1, 8'h00, 8'h00, 8'h00, 32'h0,
                levels(1000, 1000, 2500, 500, 0, 0, KIND_IGNORED, 0));
        add_row(1, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
                levels(1000, 1000, 2500, 500, 0, 0, KIND_IGNORED, 0));
        add_row(1, HDR_CMD_A, CMD_HEADLIGHT, 8'h00, 32'd5,
                levels(1000, 1000, 2500, 500, 0, 0, KIND_COMMAND, 0));
        add_row(1, HDR_CMD_B, CMD_LED | 8'h01, 8'hFF, 32'd199,
                levels(1000, 1000, 2500, 500, 0, 0, KIND_COMMAND, 0));
        add_row(1, HDR_JOY, 8'd0, 8'd0, 32'd210,
                levels(1000, 1000, 2500, 500, 0, 0, KIND_JOYSTICK, 0));
        add_row(1, HDR_JOY, 8'd255, 8'd255, 32'd220,
                levels(1300, 1150, 2500, 500, 0, 0, KIND_JOYSTICK, 0));
        add_row(1, HDR_CMD_A, 8'hFF, 8'h00, 32'd230,
                levels(1300, 1150, 2500, 500, 0, 0, KIND_COMMAND, 1));
        // debounce boundaries
        add_row(0, HDR_CMD_A, CMD_HEADLIGHT | 8'h01, 8'h00, 32'd200, no_check);
        add_row(0, HDR_CMD_A, CMD_LED, 8'h00, 32'd300, no_check);
        add_row(0, HDR_CMD_B, CMD_HEADLIGHT, 8'h00, 32'd399, no_check);
        // full servo cycles, both wrap back
        repeat (4) add_row(0, HDR_CMD_A, CMD_FIRST_SERVO | 8'h01, 8'h00, 32'd400, no_check);
        repeat (4) add_row(0, HDR_CMD_B, CMD_SECOND_SERVO, 8'h00, 32'd410, no_check);
        // toggle across the time wrap
        add_row(0, HDR_CMD_A, CMD_HEADLIGHT, 8'h00, 32'hFFFF_FF00, no_check);
        add_row(0, HDR_CMD_A, CMD_HEADLIGHT | 8'h01, 8'h00, 32'h0000_0010, no_check);
        // left stick, low throttle with full right, throttle at deadzone edge
        add_row(0, HDR_JOY, 8'd20, 8'd40, 32'd500, no_check);
        add_row(0, HDR_JOY, 8'd255, 8'd19, 32'd510, no_check);
        add_row(0, HDR_JOY, 8'd28, 8'd18, 32'd520, no_check);
        add_row(0, 8'hAB, 8'd60, 8'd60, 32'd530, no_check);
        add_row(0, HDR_CMD_B, 8'h00, 8'h00, 32'd540, no_check);

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        tx_gappy = 1'b1;
        rx_gappy = 1'b1;
        settings_used = 1;
        foreach (directed_rows[i])
            send_packet(directed_rows[i].hdr, directed_rows[i].x, directed_rows[i].y,
                        directed_rows[i].now, directed_rows[i].typed, directed_rows[i].want);
        idle_input();
        wait_drained();

        clock_ms = $urandom;
        for (int ph = 1; ph <= 6; ph++) begin
            case (ph)
                1: begin db = 16'd0;     sf = 16'd0;     tm = 16'd1000; end
                2: begin db = 16'hFFFF;  sf = 16'h01FF;  tm = 16'h07FF; end
                3: begin db = 16'($urandom_range(50, 400)); sf = 16'd300; tm = 16'd2000; end
                4: begin
                    db = 16'($urandom_range(0, 1000));
                    sf = 16'($urandom_range(0, 300));
                    tm = 16'($urandom_range(0, 999));
                end
                // raw 16-bit words, unused upper bits included
                5: begin db = 16'($urandom); sf = 16'($urandom); tm = 16'($urandom); end
                default: begin
                    db = 16'($urandom_range(0, 2000));
                    sf = 16'($urandom_range(0, 300));
                    tm = 16'($urandom_range(1000, 2000));
                end
            endcase
            write_reg(CFG_DEBOUNCE, db);
            write_reg(CFG_STEER_FORCE, sf);
            write_reg(CFG_THROTTLE_MAX, tm);
            settings_used++;

            tx_gappy = (ph == 2 || ph == 4 || ph == 6);
            rx_gappy = (ph == 2 || ph == 5 || ph == 6);
            if (ph == 3) hold_off_req = 1'b1;

            sent = 0;
            while (sent < 100) begin
                if ($urandom_range(0, 99) < 85)
                    clock_ms = clock_ms + $urandom_range(0, 2 * int'(cfg_debounce) + 4);
                else
                    clock_ms = $urandom;
                pick = $urandom_range(0, 99);
                y = 8'($urandom);
                if (pick < 40) begin
                    hdr = $urandom_range(0, 1) ? HDR_CMD_A : HDR_CMD_B;
                    case ($urandom_range(0, 4))
                        0: x = CMD_FIRST_SERVO;
                        1: x = CMD_SECOND_SERVO;
                        2: x = CMD_HEADLIGHT;
                        3: x = CMD_LED;
                        default: x = 8'($urandom);
                    endcase
                    x[0] = 1'($urandom_range(0, 1));
                end else if (pick < 85) begin
                    hdr = HDR_JOY;
                    x = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 70)) : 8'($urandom);
                    y = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 70)) : 8'($urandom);
                end else begin
                    hdr = 8'($urandom);
                    x = 8'($urandom);
                end
                send_packet(hdr, x, y, clock_ms, 1'b0, no_check);
                sent++;
            end
            idle_input();
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        $display("Ran %0d packets: %0d command, %0d joystick, %0d ignored headers",
                 n_cmd + n_joy + n_ignored, n_cmd, n_joy, n_ignored);
        $display("%0d register settings, %0d result transactions checked, %0d mismatches",
                 settings_used, results_seen, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
